FILE: sv/nss_pkg.sv
// ----------------------------------------------------------------------------
// nss_pkg
// shared types and constants of the nearest sector request scheduler
// ----------------------------------------------------------------------------
package nss_pkg;

    localparam int QUEUE_DEPTH = 32;
    localparam int SECTOR_BITS = 48;
    localparam int LEN_BITS    = 16;
    localparam int TAG_BITS    = 8;
    localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [SECTOR_BITS-1:0] sector;
        logic [LEN_BITS-1:0]    length;
        logic [TAG_BITS-1:0]    tag;
    } entry_t;

    typedef enum logic [1:0] {
        Q_HOLD   = 2'd0,
        Q_INSERT = 2'd1,
        Q_POP    = 2'd2
    } queue_op_t;

    typedef enum logic [1:0] {
        ST_ADDED      = 2'd0,
        ST_FULL       = 2'd1,
        ST_DISPATCHED = 2'd2,
        ST_EMPTY      = 2'd3
    } status_t;

endpackage

FILE: sv/nss_cell.sv
// ----------------------------------------------------------------------------
// nss_cell
// one slot of a sorted request chain: keeps, takes the new request, or
// shifts from a neighbor
// ----------------------------------------------------------------------------
module nss_cell
    import nss_pkg::*;
(
    input  logic      clk,
    input  logic      ascending,
    input  queue_op_t op,
    input  logic      occupied,
    input  entry_t    new_entry,
    input  entry_t    prev_entry,
    input  logic      prev_keep,
    input  entry_t    next_entry,
    output entry_t    entry,
    output logic      keep
);

    entry_t entry_reg;
    entry_t entry_next;
    logic   sector_ge;

    assign sector_ge = entry_reg.sector >= new_entry.sector;
    assign keep      = occupied && (sector_ge ^ ascending);
    assign entry     = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        unique case (op)
            Q_HOLD:
            begin
                entry_next = entry_reg;
            end
            Q_INSERT:
            begin
                if (!keep)
                begin
                    entry_next = prev_keep ? new_entry : prev_entry;
                end
            end
            Q_POP:
            begin
                entry_next = next_entry;
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

FILE: sv/nss_queue.sv
// ----------------------------------------------------------------------------
// nss_queue
// sorted chain of request cells with its fill count; the entry to pop is
// always held in cell zero
// ----------------------------------------------------------------------------
module nss_queue
    import nss_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              ascending,
    input  queue_op_t         op,
    input  entry_t            new_entry,
    output entry_t            first,
    output logic [FILL_W-1:0] fill
);

    logic [FILL_W-1:0]      fill_reg;
    logic [FILL_W-1:0]      fill_next;
    entry_t                 cell_entry [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] cell_keep;

    genvar k;
    generate
        for (k = 0; k < QUEUE_DEPTH; k++)
        begin : g_cell
            entry_t prev_e;
            logic   prev_k;
            entry_t next_e;

            if (k == 0)
            begin : g_head
                assign prev_e = new_entry;
                assign prev_k = 1'b1;
            end
            else
            begin : g_body
                assign prev_e = cell_entry[k-1];
                assign prev_k = cell_keep[k-1];
            end

            if (k == QUEUE_DEPTH - 1)
            begin : g_tail
                assign next_e = '0;
            end
            else
            begin : g_link
                assign next_e = cell_entry[k+1];
            end

            nss_cell u_cell (
                .clk        (clk),
                .ascending  (ascending),
                .op         (op),
                .occupied   (fill_reg > FILL_W'(k)),
                .new_entry  (new_entry),
                .prev_entry (prev_e),
                .prev_keep  (prev_k),
                .next_entry (next_e),
                .entry      (cell_entry[k]),
                .keep       (cell_keep[k])
            );
        end
    endgenerate

    always_comb
    begin
        fill_next = fill_reg;
        unique case (op)
            Q_HOLD:
            begin
                fill_next = fill_reg;
            end
            Q_INSERT:
            begin
                fill_next = fill_reg + FILL_W'(1);
            end
            Q_POP:
            begin
                fill_next = fill_reg - FILL_W'(1);
            end
            default:
            begin
                fill_next = fill_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
        end
    end

    assign first = cell_entry[0];
    assign fill  = fill_reg;

endmodule

FILE: sv/nearest_sector_request_scheduler.sv
// ----------------------------------------------------------------------------
// nearest_sector_request_scheduler
// greedy nearest-seek disk request scheduler built on two sorted cell chains
// ----------------------------------------------------------------------------
// input channel: in_valid / in_stall with kind, start_sector, sector_count
// and request_tag; kind 0 adds a request, kind 1 dispatches the nearest one
// output channel: out_valid / out_stall with status, out_tag, out_sector and
// from_upper; every input transaction gives exactly one output transaction
// requests below the head go to the lower chain, the others to the upper
// chain; each chain keeps its next candidate in cell zero, so a dispatch
// compares two registered entries and pops by shifting the chain one cell
// an accepted item is captured in the input register, and its result is
// registered at the outputs once they are free or taken; a new item is only
// accepted after the last one executed, when the chains insert or shift
// when out_stall holds a result, the next item waits in the input register
// and in_stall stays high until the result is taken
// reset clears the head position, both fill counts and all handshake state;
// the chains need no clearing pass
// ----------------------------------------------------------------------------
module nearest_sector_request_scheduler
    import nss_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   kind,
    input  logic [SECTOR_BITS-1:0] start_sector,
    input  logic [LEN_BITS-1:0]    sector_count,
    input  logic [TAG_BITS-1:0]    request_tag,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [1:0]             status,
    output logic [TAG_BITS-1:0]    out_tag,
    output logic [SECTOR_BITS-1:0] out_sector,
    output logic                   from_upper
);

    logic                   busy_reg;
    logic                   busy_next;
    logic                   kind_reg;
    entry_t                 req_reg;
    logic [SECTOR_BITS-1:0] head_reg;
    logic [SECTOR_BITS-1:0] head_next;

    logic                   out_valid_reg;
    logic                   out_valid_next;
    status_t                status_reg;
    status_t                status_next;
    logic [TAG_BITS-1:0]    tag_reg;
    logic [TAG_BITS-1:0]    tag_next;
    logic [SECTOR_BITS-1:0] sector_reg;
    logic [SECTOR_BITS-1:0] sector_next;
    logic                   from_upper_reg;
    logic                   from_upper_next;

    entry_t                 lower_first;
    entry_t                 upper_first;
    logic [FILL_W-1:0]      lower_fill;
    logic [FILL_W-1:0]      upper_fill;
    queue_op_t              lower_op;
    queue_op_t              upper_op;

    logic                   in_xact;
    logic                   exec;
    logic                   go_lower;
    logic                   target_full;
    logic                   lower_empty;
    logic                   upper_empty;
    logic [SECTOR_BITS-1:0] dist_up;
    logic [SECTOR_BITS-1:0] dist_low;
    logic                   pick_up;
    entry_t                 picked;

    assign in_stall = busy_reg;
    assign in_xact  = in_valid && !busy_reg;
    assign exec     = busy_reg && (!out_valid_reg || !out_stall);

    assign go_lower    = req_reg.sector < head_reg;
    assign target_full = go_lower ? (lower_fill == FILL_W'(QUEUE_DEPTH))
                                  : (upper_fill == FILL_W'(QUEUE_DEPTH));
    assign lower_empty = lower_fill == '0;
    assign upper_empty = upper_fill == '0;
    assign dist_up     = upper_first.sector - head_reg;
    assign dist_low    = head_reg - lower_first.sector;

    always_comb
    begin
        if (lower_empty)
        begin
            pick_up = 1'b1;
        end
        else if (upper_empty)
        begin
            pick_up = 1'b0;
        end
        else
        begin
            pick_up = dist_up < dist_low;
        end
    end

    assign picked = pick_up ? upper_first : lower_first;

    always_comb
    begin
        lower_op        = Q_HOLD;
        upper_op        = Q_HOLD;
        head_next       = head_reg;
        status_next     = status_reg;
        tag_next        = tag_reg;
        sector_next     = sector_reg;
        from_upper_next = from_upper_reg;
        if (exec)
        begin
            tag_next        = '0;
            sector_next     = '0;
            from_upper_next = 1'b0;
            if (!kind_reg)
            begin
                // add
                if (target_full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    status_next = ST_ADDED;
                    if (go_lower)
                    begin
                        lower_op = Q_INSERT;
                    end
                    else
                    begin
                        upper_op = Q_INSERT;
                    end
                end
            end
            else if (lower_empty && upper_empty)
            begin
                status_next = ST_EMPTY;
            end
            else
            begin
                // dispatch
                status_next     = ST_DISPATCHED;
                tag_next        = picked.tag;
                sector_next     = picked.sector;
                from_upper_next = pick_up;
                head_next       = picked.sector + SECTOR_BITS'(picked.length);
                if (pick_up)
                begin
                    upper_op = Q_POP;
                end
                else
                begin
                    lower_op = Q_POP;
                end
            end
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        if (in_xact)
        begin
            busy_next = 1'b1;
        end
        else if (exec)
        begin
            busy_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (exec)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    nss_queue u_lower (
        .clk       (clk),
        .rst_n     (rst_n),
        .ascending (1'b0),
        .op        (lower_op),
        .new_entry (req_reg),
        .first     (lower_first),
        .fill      (lower_fill)
    );

    // upper chain is held lowest sector first
    nss_queue u_upper (
        .clk       (clk),
        .rst_n     (rst_n),
        .ascending (1'b1),
        .op        (upper_op),
        .new_entry (req_reg),
        .first     (upper_first),
        .fill      (upper_fill)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            head_reg      <= '0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
            head_reg      <= head_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xact)
        begin
            kind_reg <= kind;
            req_reg  <= '{sector: start_sector, length: sector_count, tag: request_tag};
        end
        status_reg     <= status_next;
        tag_reg        <= tag_next;
        sector_reg     <= sector_next;
        from_upper_reg <= from_upper_next;
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign out_tag    = tag_reg;
    assign out_sector = sector_reg;
    assign from_upper = from_upper_reg;

endmodule

FILE: sv/nss_checker.sv
// ----------------------------------------------------------------------------
// nss_checker
// port-level checks of the nearest sector request scheduler
// ----------------------------------------------------------------------------
module nss_checker
    import nss_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_stall,
    input logic                   out_valid,
    input logic                   out_stall,
    input logic [1:0]             status,
    input logic [TAG_BITS-1:0]    out_tag,
    input logic [SECTOR_BITS-1:0] out_sector,
    input logic                   from_upper
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(out_tag)
            && $stable(out_sector) && $stable(from_upper))
        else $error("stalled result changed");

    // one transaction in flight at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input not held off after transaction");

    // a new result only follows a taken item
    a_result_has_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result without a pending transaction");

    // non-dispatch results carry zero payload
    a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_DISPATCHED) |->
            out_tag == '0 && out_sector == '0 && !from_upper)
        else $error("nonzero payload on non-dispatch result");

endmodule

bind nearest_sector_request_scheduler nss_checker u_nss_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .out_tag    (out_tag),
    .out_sector (out_sector),
    .from_upper (from_upper)
);
